/* sv/msp_pkg.sv */
package msp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF    = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;
  localparam int unsigned COST_BITS_DEF    = 24;

  // Fixed field widths
  localparam int unsigned VERTEX_W    = 7;
  localparam int unsigned PATH_COST_W = 24;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Register map (word index) and reset values
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 7'd12;
  localparam logic [VERTEX_W-1:0] MIN_VERTICES       = 7'd2;

  // Operation codes carried on the input tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // Result tdata layout
  localparam int unsigned OUT_VERTEX_LSB = 0;
  localparam int unsigned OUT_COST_LSB   = OUT_VERTEX_LSB + VERTEX_W;
  localparam int unsigned OUT_NEXT_LSB   = OUT_COST_LSB + PATH_COST_W;
  localparam int unsigned OUT_REACH_BIT  = OUT_NEXT_LSB + VERTEX_W;
  localparam int unsigned OUT_OVF_BIT    = OUT_REACH_BIT + 1;
  localparam int unsigned OUT_DATA_W     = ((OUT_OVF_BIT + 1 + 7) / 8) * 8;

endpackage

/* sv/multistage_graph_shortest_path_top.sv */
// Multistage graph shortest path, solved backward from the sink.
// Input stream (s_axis_*): tuser selects the operation. A load transfer stores one edge
// (source, target, weight), or sets the overflow flag if the store is full; the block is
// ready again at once. A solve transfer runs the backward pass from the sink (vertex
// vertex_count, clamped to 2..MAX_VERTICES) down to vertex 1 and then sends one result
// per vertex, vertex 1 first, with tlast on the sink. The edge store is emptied after the
// last result has been taken.
// During a solve every vertex sweeps all stored edges through one shared saturating
// adder and comparator, one edge per cycle after a memory pipeline that reads the edge
// and then the target vertex. Each result then needs a read of the vertex memory and the
// output beat. While a solve runs, s_axis_tready is low.
// If the receiver stalls, the result beat holds its data until it is taken and the
// sequencer waits. Reset empties the edge store, clears the overflow flag and sets
// vertex_count to 12; the memories keep their contents and need no clearing pass.
// Configuration is an APB port with vertex_count at byte address 0.
module multistage_graph_shortest_path_top
  import msp_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int unsigned COST_BITS    = COST_BITS_DEF,
  localparam int unsigned S_DATA_W    = ((2 * VERTEX_W + WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: edge_source, edge_target, edge_weight, zero padding
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // tuser: opcode
  input  logic                  s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: vertex_index, path_cost, next_vertex, reachable, edge_overflow,
  // zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: last (result for the sink)
  output logic                  m_axis_tlast
);

  localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned SUMW = ((WEIGHT_BITS > COST_BITS) ? WEIGHT_BITS : COST_BITS) + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VINIT = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_VEND  = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OSEND = 3'd5;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [VERTEX_W-1:0]    target;
    logic [VERTEX_W-1:0]    source;
  } edge_t;

  typedef struct packed {
    logic                 reach;
    logic [VERTEX_W-1:0]  next;
    logic [COST_BITS-1:0] cost;
  } vtx_t;

  // Configuration
  logic [VERTEX_W-1:0] vertex_count_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ?
                  {{(APB_DATA_W - VERTEX_W){1'b0}}, vertex_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RESET;
    end else if (cfg_we) begin
      vertex_count_q <= pwdata[VERTEX_W-1:0];
    end
  end

  // Control state
  logic [2:0]          state_q, state_d;
  logic [ECW-1:0]      count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [VERTEX_W-1:0] nv_q, nv_d;
  logic [VERTEX_W-1:0] i_q, i_d;
  logic [ECW-1:0]      k_q, k_d;
  logic                p1_v_q, p1_v_d;
  logic                p2_v_q, p2_v_d;

  // Memories and pipeline payload
  edge_t               edge_mem [MAX_EDGES];
  vtx_t                vtx_mem [MAX_VERTICES];
  edge_t               edge_rd_q;
  vtx_t                vtx_rd_q;
  logic [WEIGHT_BITS-1:0] p2_w_q;
  logic [VERTEX_W-1:0] p2_t_q;
  logic                best_reach_q;
  logic [COST_BITS-1:0] best_cost_q;
  logic [VERTEX_W-1:0] best_next_q;

  logic                edge_we, edge_re, vtx_we, vtx_re;
  logic [VAW-1:0]      vtx_waddr, vtx_raddr;
  vtx_t                vtx_wdata;
  edge_t               s_edge;
  logic [VERTEX_W-1:0] nv_clamped;
  logic                in_xfer, edge_ok;
  logic [SUMW-1:0]     sum;
  logic [COST_BITS-1:0] cand;
  logic                take;

  assign s_edge.source = s_axis_tdata[VERTEX_W-1:0];
  assign s_edge.target = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
  assign s_edge.weight = s_axis_tdata[2*VERTEX_W+WEIGHT_BITS-1:2*VERTEX_W];

  always_comb begin
    if (vertex_count_q < MIN_VERTICES) begin
      nv_clamped = MIN_VERTICES;
    end else if (vertex_count_q > VERTEX_W'(MAX_VERTICES)) begin
      nv_clamped = VERTEX_W'(MAX_VERTICES);
    end else begin
      nv_clamped = vertex_count_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Second pipeline stage: does the fetched edge leave the vertex under work and
  // land on an already solved vertex?
  assign edge_ok = (edge_rd_q.source == i_q) && (edge_rd_q.target > i_q) &&
                   (edge_rd_q.target <= nv_q);

  // Shared saturating adder and strict comparator
  assign sum  = SUMW'(p2_w_q) + SUMW'(vtx_rd_q.cost);
  assign cand = (sum > SUMW'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
  assign take = p2_v_q && vtx_rd_q.reach && (!best_reach_q || (cand < best_cost_q));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    nv_d      = nv_q;
    i_d       = i_q;
    k_d       = k_q;
    p1_v_d    = 1'b0;
    p2_v_d    = 1'b0;
    edge_we   = 1'b0;
    edge_re   = 1'b0;
    vtx_we    = 1'b0;
    vtx_re    = 1'b0;
    vtx_waddr = VAW'(i_q - 7'd1);
    vtx_raddr = VAW'(i_q - 7'd1);
    vtx_wdata.reach = best_reach_q;
    vtx_wdata.next  = best_next_q;
    vtx_wdata.cost  = best_cost_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == OP_LOAD) begin
            if (count_q == ECW'(MAX_EDGES)) begin
              ovf_d = 1'b1;
            end else begin
              edge_we = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else begin
            // The sink is solved by definition.
            nv_d            = nv_clamped;
            vtx_we          = 1'b1;
            vtx_waddr       = VAW'(nv_clamped - 7'd1);
            vtx_wdata.reach = 1'b1;
            vtx_wdata.next  = nv_clamped;
            vtx_wdata.cost  = '0;
            i_d             = nv_clamped - 7'd1;
            state_d         = S_VINIT;
          end
        end
      end
      S_VINIT: begin
        k_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (k_q < count_q) begin
          edge_re = 1'b1;
          p1_v_d  = 1'b1;
          k_d     = k_q + 1'b1;
        end
        if (p1_v_q && edge_ok) begin
          vtx_re    = 1'b1;
          vtx_raddr = VAW'(edge_rd_q.target - 7'd1);
          p2_v_d    = 1'b1;
        end
        if ((k_q == count_q) && !p1_v_q && !p2_v_q) begin
          state_d = S_VEND;
        end
      end
      S_VEND: begin
        vtx_we = 1'b1;
        if (i_q == 7'd1) begin
          state_d = S_ORD;
        end else begin
          i_d     = i_q - 7'd1;
          state_d = S_VINIT;
        end
      end
      S_ORD: begin
        vtx_re  = 1'b1;
        state_d = S_OSEND;
      end
      S_OSEND: begin
        if (m_axis_tready) begin
          if (i_q == nv_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 7'd1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      nv_q    <= MIN_VERTICES;
      i_q     <= 7'd1;
      k_q     <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      nv_q    <= nv_d;
      i_q     <= i_d;
      k_q     <= k_d;
      p1_v_q  <= p1_v_d;
      p2_v_q  <= p2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[count_q[EAW-1:0]] <= s_edge;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[k_q[EAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[vtx_waddr] <= vtx_wdata;
    end
    if (vtx_re) begin
      vtx_rd_q <= vtx_mem[vtx_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      p2_w_q <= edge_rd_q.weight;
      p2_t_q <= edge_rd_q.target;
    end
    if (state_q == S_VINIT) begin
      best_reach_q <= 1'b0;
      best_cost_q  <= COST_MAX;
      best_next_q  <= '0;
    end else if (take) begin
      best_reach_q <= 1'b1;
      best_cost_q  <= cand;
      best_next_q  <= p2_t_q;
    end
  end

  assign m_axis_tvalid = (state_q == S_OSEND);
  assign m_axis_tlast  = (i_q == nv_q);
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_OVF_BIT - 1){1'b0}}, ovf_q, vtx_rd_q.reach,
                          vtx_rd_q.next, PATH_COST_W'(vtx_rd_q.cost), i_q};

endmodule

/* sv/msp_checker.sv */
module msp_checker
  import msp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Results only leave while the input side is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is offered");

  // A solve keeps the input closed on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SOLVE) |=> !s_axis_tready)
    else $error("input reopened straight after a solve transfer");

  // The result for the sink ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result offered after the sink result");

  // The sink is reachable and points to itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[OUT_REACH_BIT] &&
      (m_axis_tdata[OUT_NEXT_LSB +: VERTEX_W] == m_axis_tdata[OUT_VERTEX_LSB +: VERTEX_W]))
    else $error("sink result is not self-referencing");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind multistage_graph_shortest_path_top msp_checker u_msp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_top.sv */
module tb_top
  import msp_pkg::*;
();

  localparam int unsigned IN_DATA_W     = ((2 * VERTEX_W + WEIGHT_BITS_DEF + 7) / 8) * 8;
  localparam int unsigned LONG_HOLD_OFF = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 100000;
  localparam logic [APB_ADDR_W-1:0] VERTEX_COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

  typedef struct packed {
    logic [VERTEX_W-1:0]        source;
    logic [VERTEX_W-1:0]        target;
    logic [WEIGHT_BITS_DEF-1:0] weight;
  } graph_edge_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]    vertex_index;
    logic [PATH_COST_W-1:0] path_cost;
    logic [VERTEX_W-1:0]    next_vertex;
    logic                   reachable;
    logic                   edge_overflow;
    logic                   last;
  } vertex_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Shadow of the block: register, edge store and overflow flag.
  logic [VERTEX_W-1:0] graph_vertex_count = VERTEX_COUNT_RESET;
  graph_edge_t         stored_edges[$];
  logic                graph_overflow = 1'b0;
  vertex_result_t      expected_paths[$];

  int unsigned fail_count        = 0;
  int unsigned load_count        = 0;
  int unsigned solve_count       = 0;
  int unsigned results_checked   = 0;
  int unsigned hold_off_requests = 0;
  bit          idling_on         = 1'b1;

  multistage_graph_shortest_path_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_vertices();
    if (graph_vertex_count < MIN_VERTICES) return MIN_VERTICES;
    if (graph_vertex_count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return graph_vertex_count;
  endfunction

  // Backward pass from the sink; queues one expected result per vertex.
  function automatic void solve_shortest_paths();
    logic [PATH_COST_W-1:0] best_cost [1:MAX_VERTICES_DEF];
    logic [VERTEX_W-1:0]    best_next [1:MAX_VERTICES_DEF];
    bit                     reaches   [1:MAX_VERTICES_DEF];
    logic [PATH_COST_W:0]   candidate;
    vertex_result_t         res;
    int unsigned            nv;
    int unsigned            t;
    nv = active_vertices();
    best_cost[nv] = '0;
    best_next[nv] = VERTEX_W'(nv);
    reaches[nv]   = 1'b1;
    for (int v = nv - 1; v >= 1; v--) begin
      reaches[v]   = 1'b0;
      best_cost[v] = '1;
      best_next[v] = '0;
      foreach (stored_edges[k]) begin
        t = stored_edges[k].target;
        // Malformed edges and edges into dead ends take no part.
        if (stored_edges[k].source != v || t <= v || t > nv || !reaches[t]) continue;
        candidate = {1'b0, best_cost[t]} + stored_edges[k].weight;
        if (candidate[PATH_COST_W]) candidate[PATH_COST_W-1:0] = '1;
        // Strictly smaller only, so the earliest loaded edge keeps a tie.
        if (!reaches[v] || candidate[PATH_COST_W-1:0] < best_cost[v]) begin
          reaches[v]   = 1'b1;
          best_cost[v] = candidate[PATH_COST_W-1:0];
          best_next[v] = VERTEX_W'(t);
        end
      end
    end
    for (int v = 1; v <= nv; v++) begin
      res.vertex_index  = VERTEX_W'(v);
      res.path_cost     = reaches[v] ? best_cost[v] : '1;
      res.next_vertex   = reaches[v] ? best_next[v] : '0;
      res.reachable     = reaches[v];
      res.edge_overflow = graph_overflow;
      res.last          = (v == nv);
      expected_paths    = {expected_paths, res};
    end
    stored_edges.delete();
    graph_overflow = 1'b0;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : transfer_monitor
    vertex_result_t want;
    graph_edge_t    loaded;
    if (!rst_ni) begin
      graph_vertex_count = VERTEX_COUNT_RESET;
      stored_edges.delete();
      graph_overflow = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == VERTEX_COUNT_ADDR)
        graph_vertex_count = pwdata[VERTEX_W-1:0];
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_paths.size() == 0) begin
          $error("result for vertex %0d arrived with nothing expected",
                 m_axis_tdata[OUT_VERTEX_LSB +: VERTEX_W]);
          fail_count++;
        end else begin
          want = expected_paths.pop_front();
          results_checked++;
          check_field("vertex_index", want.vertex_index,
                      m_axis_tdata[OUT_VERTEX_LSB +: VERTEX_W]);
          check_field("path_cost", want.path_cost, m_axis_tdata[OUT_COST_LSB +: PATH_COST_W]);
          check_field("next_vertex", want.next_vertex, m_axis_tdata[OUT_NEXT_LSB +: VERTEX_W]);
          check_field("reachable", want.reachable, m_axis_tdata[OUT_REACH_BIT]);
          check_field("edge_overflow", want.edge_overflow, m_axis_tdata[OUT_OVF_BIT]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_SOLVE) begin
          solve_count++;
          solve_shortest_paths();
        end else begin
          load_count++;
          loaded.source = s_axis_tdata[0 +: VERTEX_W];
          loaded.target = s_axis_tdata[VERTEX_W +: VERTEX_W];
          loaded.weight = s_axis_tdata[2 * VERTEX_W +: WEIGHT_BITS_DEF];
          if (stored_edges.size() < MAX_EDGES_DEF) stored_edges = {stored_edges, loaded};
          else graph_overflow = 1'b1;
        end
      end
    end
  end

  initial begin : result_receiver
    int unsigned stall_left;
    int unsigned served;
    stall_left    = 0;
    served        = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (served != hold_off_requests) begin
        served++;
        stall_left = LONG_HOLD_OFF;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [WEIGHT_BITS_DEF-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_BITS_DEF'($urandom_range(0, 15));
      default: return WEIGHT_BITS_DEF'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic op, input logic [VERTEX_W-1:0] source,
                           input logic [VERTEX_W-1:0] target,
                           input logic [WEIGHT_BITS_DEF-1:0] weight);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - 2 * VERTEX_W - WEIGHT_BITS_DEF){1'b0}}, weight, target, source};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // A solve with random contents in the fields that it ignores.
  task automatic send_solve();
    send_item(OP_SOLVE, VERTEX_W'($urandom()), VERTEX_W'($urandom()),
              WEIGHT_BITS_DEF'($urandom()));
  endtask

  task automatic send_layered_edge(input int unsigned nv, input int unsigned span);
    int unsigned source;
    source = $urandom_range(1, nv - 1);
    send_item(OP_LOAD, VERTEX_W'(source),
              VERTEX_W'($urandom_range(source + 1, (source + span < nv) ? source + span : nv)),
              pick_weight());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_paths.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VERTEX_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom_range(0, 1) ? $urandom() : '0;
    word[VERTEX_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERTEX_COUNT_ADDR;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    // Read back in the next transfer; psel stays high between the two.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("vertex_count read back", value, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_default_count();
    send_item(OP_LOAD, 7'd1, 7'd12, 16'd0);
    send_item(OP_LOAD, 7'd1, 7'd11, 16'd7);
    send_item(OP_LOAD, 7'd11, 7'd12, '1);
    send_item(OP_SOLVE, '1, '1, '1);
  endtask

  task automatic test_malformed_edges();
    wait_drained();
    write_vertex_count(7'd5);
    send_item(OP_LOAD, 7'd0, 7'd5, 16'd1);
    send_item(OP_LOAD, 7'd3, 7'd3, 16'd1);
    send_item(OP_LOAD, 7'd4, 7'd2, 16'd1);
    send_item(OP_LOAD, 7'd4, 7'd6, 16'd1);
    send_item(OP_LOAD, 7'd2, 7'd127, 16'd1);
    // Vertex 4 has no usable edge, so this one leads nowhere.
    send_item(OP_LOAD, 7'd3, 7'd4, 16'd9);
    send_item(OP_LOAD, 7'd3, 7'd5, 16'd2);
    send_item(OP_LOAD, 7'd1, 7'd3, 16'd4);
    send_item(OP_LOAD, 7'd1, 7'd5, 16'd6);
    send_item(OP_LOAD, 7'd2, 7'd4, 16'd0);
    send_item(OP_SOLVE, '1, '1, '1);
  endtask

  task automatic test_count_limits();
    wait_drained();
    write_vertex_count(7'd0);
    send_item(OP_LOAD, 7'd1, 7'd2, '1);
    send_item(OP_SOLVE, '0, '0, '0);
    wait_drained();
    write_vertex_count(7'd1);
    send_item(OP_SOLVE, '0, '0, '0);
    wait_drained();
    write_vertex_count('1);
    send_item(OP_LOAD, 7'd63, 7'd64, '1);
    send_item(OP_LOAD, 7'd1, 7'd63, 16'd0);
    send_item(OP_LOAD, 7'd1, 7'd64, '1);
    send_item(OP_SOLVE, '0, '1, '0);
    wait_drained();
    write_vertex_count(VERTEX_W'(MAX_VERTICES_DEF));
    send_item(OP_SOLVE, '1, '0, '1);
  endtask

  task automatic test_store_full();
    int unsigned nv;
    wait_drained();
    write_vertex_count(VERTEX_W'($urandom_range(8, MAX_VERTICES_DEF)));
    nv = active_vertices();
    repeat (MAX_EDGES_DEF + 3) send_layered_edge(nv, 4);
    send_solve();
    // The flag must not outlive the solve that reported it.
    repeat (2) send_layered_edge(nv, 4);
    send_solve();
  endtask

  task automatic test_backpressure();
    int unsigned nv;
    wait_drained();
    write_vertex_count(7'd10);
    nv = active_vertices();
    hold_off_requests++;
    repeat (6) send_layered_edge(nv, 3);
    send_solve();
    repeat (8) send_layered_edge(nv, 3);
    send_solve();
    wait_drained();
    repeat (5) send_layered_edge(nv, 9);
    send_solve();
  endtask

  task automatic test_random_graphs(input int unsigned item_budget);
    int unsigned sent;
    int unsigned nv;
    int unsigned pick;
    int unsigned edges;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 2) != 0) begin
        wait_drained();
        pick = $urandom_range(0, 19);
        if (pick == 0) write_vertex_count(VERTEX_W'($urandom_range(0, 1)));
        else if (pick == 1)
          write_vertex_count(VERTEX_W'($urandom_range(MAX_VERTICES_DEF + 1, 127)));
        else if (pick == 2) write_vertex_count(VERTEX_W'(MAX_VERTICES_DEF));
        else if (pick <= 5)
          write_vertex_count(VERTEX_W'($urandom_range(13, MAX_VERTICES_DEF - 1)));
        else write_vertex_count(VERTEX_W'($urandom_range(MIN_VERTICES, 12)));
      end
      nv   = active_vertices();
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        edges = $urandom_range(1, 24);
        repeat (edges) send_layered_edge(nv, 3);
      end else if (pick <= 7) begin
        // A chain through every vertex, often at full weight, plus a few shortcuts.
        for (int v = 1; v < nv; v++)
          send_item(OP_LOAD, VERTEX_W'(v), VERTEX_W'(v + 1),
                    $urandom_range(0, 1) ? 16'hFFFF : pick_weight());
        edges = $urandom_range(0, 4);
        repeat (edges) send_layered_edge(nv, nv);
        edges += nv - 1;
      end else begin
        edges = $urandom_range(1, 16);
        repeat (edges)
          send_item(OP_LOAD, VERTEX_W'($urandom()), VERTEX_W'($urandom()),
                    WEIGHT_BITS_DEF'($urandom()));
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
      // Now and then the edges are left to pile up into the next graph.
      if ($urandom_range(0, 9) != 0) begin
        send_solve();
        edges++;
      end
      sent += edges;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_count();
    test_malformed_edges();
    test_count_limits();
    test_store_full();
    test_backpressure();
    test_random_graphs(60);
    wait_drained();
    idling_on = 1'b0;
    test_random_graphs(30);
    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d edge loads and %0d solves, vertex counts from below the minimum",
             load_count, solve_count);
    $display("to above the maximum, a full edge store and long result stalls; %0d results checked.",
             results_checked);
    if (fail_count == 0 && expected_paths.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/msp_pkg.sv
sv/multistage_graph_shortest_path_top.sv
sv/msp_checker.sv
tb/tb_top.sv
